// ----- hdl/fnvh_pkg.sv -----
// Shared types, constants and functions for the FNV-1a string hash block.
// Used by the front, queue, back and top-level modules; depends on nothing.
`default_nettype none

package fnvh_pkg;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] HASH_MULT = 32'd16777619;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] OP_MIDDLE = 2'd0;
  localparam logic [1:0] OP_LAST   = 2'd1;
  localparam logic [1:0] OP_EMPTY  = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] data;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [31:0] avalanche(input logic [31:0] h_in);
    logic [31:0] h;
    h = h_in;
    h = h + (h << 13);
    h = h ^ (h >> 7);
    h = h + (h << 3);
    h = h ^ (h >> 17);
    h = h + (h << 5);
    return h;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/fnvh_front.sv -----
// Front end: takes input transfers, extends the byte and classifies the item.
// Depends on fnvh_pkg for the item type and operation codes.
`default_nettype none

module fnvh_front
  import fnvh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        sign_extend,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  key_byte,
  input  wire logic        last_byte,
  input  wire logic        empty_key,
  input  wire queue_status_t q_status,
  output logic             push,
  output item_t            push_item
);

  logic  held;
  item_t item;
  item_t item_next;
  logic  accept;

  assign push     = held && !q_status.full;
  assign in_ready = !held || !q_status.full;
  assign accept   = in_valid && in_ready;
  assign push_item = item;

  always_comb begin
    item_next.data = {{24{sign_extend & key_byte[7]}}, key_byte};
    priority if (empty_key) begin
      item_next.op = OP_EMPTY;
    end else if (last_byte) begin
      item_next.op = OP_LAST;
    end else begin
      item_next.op = OP_MIDDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/fnvh_queue.sv -----
// Short first-in first-out queue between the front end and the hash engine.
// Depends on fnvh_pkg for the item type, status type and depth constants.
`default_nettype none

module fnvh_queue
  import fnvh_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  input  wire logic  pop,
  output item_t      head,
  output queue_status_t status
);

  item_t                  slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  assign status.full  = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/fnvh_back.sv -----
// Hash engine: running FNV-1a state, finalisation stage and output register.
// Depends on fnvh_pkg for the item type, operation codes and avalanche function.
`default_nettype none

module fnvh_back
  import fnvh_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire item_t head,
  input  wire queue_status_t q_status,
  output logic       pop,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [31:0] hash_value
);

  logic [31:0] running_hash;
  logic [31:0] product;
  logic        fin_valid;
  logic [31:0] fin_value;
  logic        fin_move;
  logic        fin_ready;

  assign product   = (running_hash ^ head.data) * HASH_MULT;
  assign fin_move  = fin_valid && (!out_valid || out_ready);
  assign fin_ready = !fin_valid || fin_move;
  assign pop       = !q_status.empty && ((head.op == OP_MIDDLE) || fin_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= FNV_BASIS;
      fin_valid    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (pop) begin
        unique case (head.op)
          OP_MIDDLE: running_hash <= product;
          OP_LAST:   running_hash <= FNV_BASIS;
          OP_EMPTY:  running_hash <= FNV_BASIS;
          default:   running_hash <= FNV_BASIS;
        endcase
      end
      if (pop && (head.op != OP_MIDDLE)) begin
        fin_valid <= 1'b1;
      end else if (fin_move) begin
        fin_valid <= 1'b0;
      end
      if (fin_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The avalanche maps zero to zero, so an empty key carries zero through it.
  always_ff @(posedge clk) begin
    if (pop && (head.op != OP_MIDDLE)) begin
      fin_value <= (head.op == OP_LAST) ? product : '0;
    end
    if (fin_move) begin
      hash_value <= avalanche(fin_value);
    end
  end

endmodule

`default_nettype wire

// ----- hdl/fnv1a_string_hash_with_finalizer.sv -----
// Top level of the FNV-1a string hash with avalanche finaliser.
// Instantiates fnvh_front, fnvh_queue and fnvh_back; depends on fnvh_pkg.
`default_nettype none

// Key bytes arrive one per input transfer and are hashed at one byte per clock cycle, set by
// the combinational constant multiply in the hash engine's state loop, while the queue is not
// stalled by output back-pressure. A byte marked last, or an item marked as an empty key,
// produces one 32-bit result through the item, queue, finalisation and output registers; an
// empty key gives zero. A four-entry queue separates the front end from the hash engine, so
// the input keeps taking bytes while a result waits on the output, until the queue fills. The
// sign-extension register resets to one and should be written only while no key is in flight.
module fnv1a_string_hash_with_finalizer
  import fnvh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write_en,
  input  wire logic        cfg_write_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  key_byte,
  input  wire logic        last_byte,
  input  wire logic        empty_key,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      hash_value
);

  logic          sign_extend_bytes;
  logic          push;
  logic          pop;
  item_t         push_item;
  item_t         head;
  queue_status_t q_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      sign_extend_bytes <= 1'b1;
    end else if (cfg_write_en) begin
      sign_extend_bytes <= cfg_write_data;
    end
  end

  fnvh_front u_front (
    .clk        (clk),
    .rst        (rst),
    .sign_extend(sign_extend_bytes),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .key_byte   (key_byte),
    .last_byte  (last_byte),
    .empty_key  (empty_key),
    .q_status   (q_status),
    .push       (push),
    .push_item  (push_item)
  );

  fnvh_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  fnvh_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hash_value(hash_value)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_status.full)
    else $error("Queue written while full.");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("Queue read while empty.");

  a_idle_after_reset: assert property (@(posedge clk)
    rst |=> (!out_valid && q_status.empty))
    else $error("Output or queue not cleared by reset.");

  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (q_status.full && !pop) |=> q_status.full)
    else $error("Queue occupancy fell without a read.");
`endif

endmodule

`default_nettype wire
